### rtl/ktp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktp_pkg
// Types, character codes and helpers shared by the keymap text parser.
// ----------------------------------------------------------------------------
package ktp_pkg;

  // Request types on the two channels
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_req_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] key_code;
    logic [7:0] char_value;
  } evt_req_t;

  // Event kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_PLAIN = 2'd1;
  localparam logic [1:0] KIND_SHIFT = 2'd2;

  // Characters the parser reacts to
  localparam logic [7:0] CH_HASH   = 8'h23;  // '#'
  localparam logic [7:0] CH_EQ     = 8'h3D;  // '='
  localparam logic [7:0] CH_X      = 8'h78;  // 'x'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_QUOTE  = 8'h27;  // '\''
  localparam logic [7:0] CH_BSLASH = 8'h5C;  // '\\'
  localparam logic [7:0] CH_N      = 8'h6E;  // 'n'
  localparam logic [7:0] CH_T      = 8'h74;  // 't'
  localparam logic [7:0] CH_B      = 8'h62;  // 'b'
  localparam logic [7:0] CH_R      = 8'h72;  // 'r'

  // Hex digit value; anything that is not a hex digit reads as zero
  function automatic logic [3:0] nibble(input logic [7:0] b);
    logic [7:0] d;
    d = 8'd0;
    if (b >= 8'h30 && b <= 8'h39) d = b - 8'h30;
    else if (b >= 8'h41 && b <= 8'h46) d = b - 8'h37;
    else if (b >= 8'h61 && b <= 8'h66) d = b - 8'h57;
    return d[3:0];
  endfunction

  // Character after a backslash: the four named escapes, else itself
  function automatic logic [7:0] escape_char(input logic [7:0] b);
    logic [7:0] c;
    case (b)
      CH_N:    c = CH_LF;
      CH_T:    c = CH_TAB;
      CH_B:    c = CH_BS;
      CH_R:    c = CH_CR;
      default: c = b;
    endcase
    return c;
  endfunction

endpackage

### rtl/keymap_text_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keymap_text_parser_unit
// Streams keymap text one byte per request and emits table-write events.
// ----------------------------------------------------------------------------
//   channel | dir | handshake            | payload
//   text    | in  | text_valid/text_stall | ktp_pkg::text_req_t
//   evt     | out | evt_valid/evt_stall   | ktp_pkg::evt_req_t
//
// One text byte is taken per cycle while text_stall is low; its event
// (if any) is in the output register the next cycle. The parse state
// updates in the accepting cycle. Reset (rst, synchronous) returns to
// line start and arms the clear event. text_stall is high only while an
// event sits in the output register and evt_stall holds it there.
// ----------------------------------------------------------------------------
module keymap_text_parser_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               text_valid,
  output logic               text_stall,
  input  ktp_pkg::text_req_t text,
  output logic               evt_valid,
  input  logic               evt_stall,
  output ktp_pkg::evt_req_t  evt
);

  typedef enum logic [3:0] {
    PH_LINE_START,
    PH_SKIP_LINE,
    PH_SAW_ZERO,
    PH_CODE,
    PH_FIND_EQ,
    PH_WS,
    PH_CHAR,
    PH_ESC,
    PH_HEX0,
    PH_HEX1,
    PH_CLOSE
  } phase_t;

  phase_t     parse_phase, parse_phase_next;
  logic       shift_selected, shift_selected_next;
  logic [7:0] code_accum, code_accum_next;
  logic [7:0] hex_accum, hex_accum_next;
  logic       digit_index, digit_index_next;
  logic       file_start;

  logic       wr_valid;
  logic [7:0] wr_char;
  logic [7:0] b;
  logic [3:0] nib;
  logic       take;
  phase_t     skip_ph, ws_ph;

  assign b          = text.text_byte;
  assign nib        = ktp_pkg::nibble(b);
  assign text_stall = evt_valid && evt_stall;
  assign take       = text_valid && !text_stall;

  // Common exits: end of line, and the blank/quote step before a character
  always_comb begin
    skip_ph = (b == ktp_pkg::CH_LF) ? PH_LINE_START : PH_SKIP_LINE;
    if (b == ktp_pkg::CH_SPACE || b == ktp_pkg::CH_TAB) ws_ph = PH_WS;
    else if (b == ktp_pkg::CH_QUOTE) ws_ph = PH_CHAR;
    else ws_ph = skip_ph;
  end

  // Byte-level parse step
  always_comb begin
    parse_phase_next    = parse_phase;
    shift_selected_next = shift_selected;
    code_accum_next     = code_accum;
    hex_accum_next      = hex_accum;
    digit_index_next    = digit_index;
    wr_valid            = 1'b0;
    wr_char             = b;
    case (parse_phase)
      PH_LINE_START: begin
        if (b == ktp_pkg::CH_SPACE || b == ktp_pkg::CH_TAB ||
            b == ktp_pkg::CH_CR || b == ktp_pkg::CH_LF) parse_phase_next = PH_LINE_START;
        else if (b == ktp_pkg::CH_ZERO) parse_phase_next = PH_SAW_ZERO;
        else parse_phase_next = PH_SKIP_LINE;  // comments land here too
      end
      PH_SKIP_LINE: parse_phase_next = skip_ph;
      PH_SAW_ZERO: begin
        if (b == ktp_pkg::CH_X && !text.end_of_text) begin
          parse_phase_next    = PH_CODE;
          code_accum_next     = 8'd0;
          digit_index_next    = 1'b0;
          shift_selected_next = 1'b0;
        end else begin
          parse_phase_next = skip_ph;
        end
      end
      PH_CODE: begin
        code_accum_next = {code_accum[3:0], nib};
        if (!digit_index) begin
          digit_index_next = 1'b1;
        end else begin
          digit_index_next = 1'b0;
          parse_phase_next = PH_FIND_EQ;
        end
      end
      PH_FIND_EQ: if (b == ktp_pkg::CH_EQ) parse_phase_next = PH_WS;
      PH_WS: parse_phase_next = ws_ph;
      PH_CHAR: begin
        // a backslash as the final byte is taken literally
        if (b == ktp_pkg::CH_BSLASH && !text.end_of_text) begin
          parse_phase_next = PH_ESC;
        end else begin
          wr_valid         = 1'b1;
          parse_phase_next = PH_CLOSE;
        end
      end
      PH_ESC: begin
        if (b == ktp_pkg::CH_X) begin
          hex_accum_next   = 8'd0;
          parse_phase_next = PH_HEX0;
        end else begin
          wr_valid         = 1'b1;
          wr_char          = ktp_pkg::escape_char(b);
          parse_phase_next = PH_CLOSE;
        end
      end
      PH_HEX0: begin
        hex_accum_next   = {4'd0, nib};
        parse_phase_next = PH_HEX1;
      end
      PH_HEX1: begin
        hex_accum_next   = {hex_accum[3:0], nib};
        wr_valid         = 1'b1;
        wr_char          = {hex_accum[3:0], nib};
        parse_phase_next = PH_CLOSE;
      end
      PH_CLOSE: begin
        if (!shift_selected) begin
          shift_selected_next = 1'b1;
          parse_phase_next    = (b == ktp_pkg::CH_QUOTE) ? PH_WS : ws_ph;
        end else begin
          parse_phase_next = (b == ktp_pkg::CH_QUOTE) ? PH_SKIP_LINE : skip_ph;
        end
      end
      default: parse_phase_next = PH_SKIP_LINE;
    endcase
  end

  // Parse state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= PH_LINE_START;
      shift_selected <= 1'b0;
      code_accum     <= 8'd0;
      hex_accum      <= 8'd0;
      digit_index    <= 1'b0;
      file_start     <= 1'b1;
      evt_valid      <= 1'b0;
    end else begin
      if (take) begin
        // result register
        if (file_start) begin
          evt_valid <= 1'b1;
          evt       <= '{event_kind: ktp_pkg::KIND_CLEAR, key_code: 8'd0, char_value: 8'd0};
        end else begin
          evt_valid <= wr_valid;
          evt       <= '{event_kind: shift_selected ? ktp_pkg::KIND_SHIFT
                                                    : ktp_pkg::KIND_PLAIN,
                         key_code: code_accum_next, char_value: wr_char};
        end
        // state; end of text starts a new file
        if (text.end_of_text) begin
          parse_phase    <= PH_LINE_START;
          shift_selected <= 1'b0;
          code_accum     <= 8'd0;
          hex_accum      <= 8'd0;
          digit_index    <= 1'b0;
          file_start     <= 1'b1;
        end else begin
          parse_phase    <= parse_phase_next;
          shift_selected <= shift_selected_next;
          code_accum     <= code_accum_next;
          hex_accum      <= hex_accum_next;
          digit_index    <= digit_index_next;
          file_start     <= 1'b0;
        end
      end else if (!evt_stall) begin
        evt_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/ktp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktp_checker
// Port-level checks for keymap_text_parser_unit, bound into that module.
// ----------------------------------------------------------------------------
module ktp_checker (
  input logic               clk,
  input logic               rst,
  input logic               text_valid,
  input logic               text_stall,
  input ktp_pkg::text_req_t text,
  input logic               evt_valid,
  input logic               evt_stall,
  input ktp_pkg::evt_req_t  evt
);

  // A held event stays put
  a_evt_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_stall |=> evt_valid && $stable(evt))
    else $error("event changed while stalled");

  // Input backpressure only comes from a stalled pending event
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> evt_valid && evt_stall)
    else $error("text stalled without a stalled event");

  // A new event only follows an accepted byte
  a_evt_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(evt_valid) |-> $past(text_valid && !text_stall))
    else $error("event without accepted byte");

  // The first byte after end of text yields a clear
  a_new_file: assert property (@(posedge clk) disable iff (rst)
    (text_valid && !text_stall && text.end_of_text) ##1 (text_valid && !text_stall)
    |=> evt_valid && evt.event_kind == ktp_pkg::KIND_CLEAR)
    else $error("missing clear at file start");

  // Clear events carry zero payload
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt.event_kind == ktp_pkg::KIND_CLEAR |->
    evt.key_code == 8'd0 && evt.char_value == 8'd0)
    else $error("clear event with nonzero payload");

endmodule

bind keymap_text_parser_unit ktp_checker u_ktp_checker (
  .clk        (clk),
  .rst        (rst),
  .text_valid (text_valid),
  .text_stall (text_stall),
  .text       (text),
  .evt_valid  (evt_valid),
  .evt_stall  (evt_stall),
  .evt        (evt)
);
